FILE: hw/rtl/msf_pkg.sv
// Shared constants, codes and types of the microphone sample feed.
package msf_pkg;

  localparam int unsigned CAPTURE_DEPTH = 4096;
  localparam int unsigned SAMPLE_DEPTH  = 32768;

  localparam int unsigned CAP_AW        = $clog2(CAPTURE_DEPTH);
  localparam int unsigned CAP_RAM_DEPTH = 2 ** (CAP_AW + 1);
  localparam int unsigned RP_W          = CAP_AW + 1;
  localparam int unsigned SAMPLE_AW     = $clog2(SAMPLE_DEPTH);

  localparam int unsigned ADDR_W    = 15;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned BTN_W     = LEN_W + 1;
  localparam int unsigned NOISE_LEN = 32;
  localparam int unsigned NOISE_AW  = $clog2(NOISE_LEN);

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = LEN_W;

  localparam logic [7:0] SILENCE = 8'h80;

  localparam logic [7:0] NOISE_TABLE [NOISE_LEN] = '{
    8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hF5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h8E, 8'hFF,
    8'hF4, 8'hE1, 8'hBF, 8'h9A, 8'h71, 8'h58, 8'h5B, 8'h5F,
    8'h62, 8'hC2, 8'h25, 8'h05, 8'h01, 8'h01, 8'h01, 8'h01
  };

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_LOAD    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_PHYS  = 2'd0,
    MODE_TABLE = 2'd1,
    MODE_PRNG  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_LOADED = 2'd1,
    REG_LENGTH = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    SRC_CONST   = 2'd0,
    SRC_CAPTURE = 2'd1,
    SRC_STORE   = 2'd2
  } src_e;

  typedef struct packed {
    logic       valid;
    src_e       sel;
    logic [7:0] src_byte;
    logic       phase;
  } issue_t;

endpackage

FILE: hw/rtl/mic_sample_feed.sv
// Top level of the microphone sample feed.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_axis   | in        | tvalid / tready    | tdata, tuser = command
//  m_axis   | out       | tvalid / tready    | tdata = read_value, shown_sample
//  cfg      | in        | valid / ready      | index, data (ready always high)
//
//  One beat per cycle while s_axis_tready is high; a read beat's result goes through
//  the capture or sample RAM read, then the output register.
//  Capture and load beats write their RAM in the accept cycle and give no result.
//  No clearing pass after reset: per-bank fill tracking makes unwritten capture
//  entries read as silence. The sample store holds garbage until loaded.
//  A stalled output blocks input only once both the RAM stage and output are full.
module mic_sample_feed (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] data_byte, [22:8] sample_address, [23] button_pressed, [24] movie_active
  input  logic [msf_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [msf_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] read_value, [15:8] shown_sample
  output logic [msf_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msf_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import msf_pkg::*;

  logic                 take;
  logic                 accept;
  logic                 cap_we, cap_re, sto_we, sto_re;
  logic [CAP_AW:0]      cap_addr;
  logic [SAMPLE_AW-1:0] sto_addr;
  logic [7:0]           cap_rdata, sto_rdata;
  issue_t               issue;

  assign s_axis_tready_o = take;
  assign accept          = s_axis_tvalid_i && take;
  assign cfg_ready_o     = 1'b1;

  msf_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .cmd_i            (s_axis_tuser_i),
    .sample_address_i (s_axis_tdata_i[22:8]),
    .button_pressed_i (s_axis_tdata_i[23]),
    .movie_active_i   (s_axis_tdata_i[24]),
    .cap_we_o         (cap_we),
    .cap_re_o         (cap_re),
    .cap_addr_o       (cap_addr),
    .sto_we_o         (sto_we),
    .sto_re_o         (sto_re),
    .sto_addr_o       (sto_addr),
    .issue_o          (issue)
  );

  msf_ram #(
    .Width (8),
    .Depth (CAP_RAM_DEPTH)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .re_i    (cap_re),
    .addr_i  (cap_addr),
    .wdata_i (s_axis_tdata_i[7:0]),
    .rdata_o (cap_rdata)
  );

  msf_ram #(
    .Width (8),
    .Depth (SAMPLE_DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (sto_we),
    .re_i    (sto_re),
    .addr_i  (sto_addr),
    .wdata_i (s_axis_tdata_i[7:0]),
    .rdata_o (sto_rdata)
  );

  msf_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .issue_i         (issue),
    .cap_rdata_i     (cap_rdata),
    .sto_rdata_i     (sto_rdata),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

FILE: hw/rtl/msf_ram.sv
// Generic single-port RAM with registered read data.
module msf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/msf_ctrl.sv
// Front stage: configuration, pointers, button position, LFSR and memory requests.
module msf_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [msf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [msf_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic                            accept_i,
  input  logic [1:0]                      cmd_i,
  input  logic [msf_pkg::ADDR_W-1:0]      sample_address_i,
  input  logic                            button_pressed_i,
  input  logic                            movie_active_i,
  output logic                            cap_we_o,
  output logic                            cap_re_o,
  output logic [msf_pkg::CAP_AW:0]        cap_addr_o,
  output logic                            sto_we_o,
  output logic                            sto_re_o,
  output logic [msf_pkg::SAMPLE_AW-1:0]   sto_addr_o,
  output msf_pkg::issue_t                 issue_o
);
  import msf_pkg::*;

  localparam logic [31:0] SampleDepthW = 32'(SAMPLE_DEPTH);

  logic [1:0]        mode_q;
  logic              loaded_q;
  logic [LEN_W-1:0]  length_q;

  logic [RP_W-1:0]   read_pos_q, read_pos_d;
  logic              play_bank_q, play_bank_d;
  logic              write_bank_q, write_bank_d;
  logic [CAP_AW-1:0] cap_idx_q, cap_idx_d;
  logic [1:0]        bank_full_q, bank_full_d;
  logic [BTN_W-1:0]  btn_pos_q, btn_pos_d;
  logic [7:0]        lfsr_q, lfsr_d;

  logic [CAP_AW-1:0] play_idx;
  logic              cap_hit;
  logic [BTN_W:0]    btn_inc;
  logic [LEN_W-1:0]  len_eff;
  logic [BTN_W:0]    limit_store;
  logic [BTN_W:0]    limit_noise;
  logic [BTN_W-1:0]  btn_store_next;
  logic [BTN_W-1:0]  btn_noise_next;
  logic [BTN_W-2:0]  sto_idx;
  logic              sto_in_range;
  logic [7:0]        lfsr_seed;
  logic [7:0]        lfsr_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PHYS;
      loaded_q <= 1'b0;
      length_q <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_LOADED: loaded_q <= cfg_data_i[0];
        REG_LENGTH: length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign play_idx = read_pos_q[RP_W-1:1];
  assign cap_hit  = bank_full_q[play_bank_q] ||
                    ((write_bank_q == play_bank_q) && (play_idx < cap_idx_q));

  assign btn_inc        = {1'b0, btn_pos_q} + (BTN_W+1)'(1);
  assign len_eff        = (length_q == '0) ? LEN_W'(1) : length_q;
  assign limit_store    = {1'b0, len_eff, 1'b0};
  assign limit_noise    = (BTN_W+1)'(2 * NOISE_LEN);
  assign btn_store_next = (btn_inc >= limit_store) ? '0 : btn_inc[BTN_W-1:0];
  assign btn_noise_next = (btn_inc >= limit_noise) ? '0 : btn_inc[BTN_W-1:0];

  assign sto_idx      = btn_pos_q[BTN_W-1:1];
  assign sto_in_range = 32'(sto_idx) < SampleDepthW;

  assign lfsr_seed = (lfsr_q == '0) ? 8'h01 : lfsr_q;
  assign lfsr_new  = {lfsr_seed[6:0], lfsr_seed[7] ^ lfsr_seed[5] ^ lfsr_seed[4] ^ lfsr_seed[3]};

  always_comb begin
    read_pos_d   = read_pos_q;
    play_bank_d  = play_bank_q;
    write_bank_d = write_bank_q;
    cap_idx_d    = cap_idx_q;
    bank_full_d  = bank_full_q;
    btn_pos_d    = btn_pos_q;
    lfsr_d       = lfsr_q;
    cap_we_o     = 1'b0;
    cap_re_o     = 1'b0;
    cap_addr_o   = {write_bank_q, cap_idx_q};
    sto_we_o     = 1'b0;
    sto_re_o     = 1'b0;
    sto_addr_o   = SAMPLE_AW'(sample_address_i);
    issue_o      = '{valid: 1'b0, sel: SRC_CONST, src_byte: SILENCE, phase: read_pos_q[0]};
    if (accept_i) begin
      case (cmd_e'(cmd_i))
        CMD_CAPTURE: begin
          cap_we_o = 1'b1;
          if (cap_idx_q == CAP_AW'(CAPTURE_DEPTH - 1)) begin
            cap_idx_d                 = '0;
            write_bank_d              = ~write_bank_q;
            bank_full_d[write_bank_q] = 1'b1;
          end else begin
            cap_idx_d = cap_idx_q + CAP_AW'(1);
          end
        end
        CMD_LOAD: begin
          sto_we_o = 32'(sample_address_i) < SampleDepthW;
        end
        CMD_READ: begin
          issue_o.valid = 1'b1;
          if (mode_q == MODE_PHYS) begin
            if (!movie_active_i && cap_hit) begin
              cap_re_o    = 1'b1;
              cap_addr_o  = {play_bank_q, play_idx};
              issue_o.sel = SRC_CAPTURE;
            end
          end else if (button_pressed_i) begin
            if (loaded_q) begin
              btn_pos_d = btn_store_next;
              if (sto_in_range) begin
                sto_re_o    = 1'b1;
                sto_addr_o  = SAMPLE_AW'(sto_idx);
                issue_o.sel = SRC_STORE;
              end
            end else begin
              btn_pos_d = btn_noise_next;
              if (mode_q == MODE_TABLE) begin
                issue_o.src_byte = NOISE_TABLE[btn_pos_q[NOISE_AW:1]];
              end else begin
                lfsr_d           = lfsr_new;
                issue_o.src_byte = lfsr_new;
              end
            end
          end else begin
            btn_pos_d = '0;
          end
          if (read_pos_q == RP_W'(2 * CAPTURE_DEPTH - 1)) begin
            read_pos_d  = '0;
            play_bank_d = ~play_bank_q;
          end else begin
            read_pos_d = read_pos_q + RP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q   <= '0;
      play_bank_q  <= 1'b1;
      write_bank_q <= 1'b0;
      cap_idx_q    <= '0;
      bank_full_q  <= '0;
      btn_pos_q    <= '0;
      lfsr_q       <= 8'h01;
    end else begin
      read_pos_q   <= read_pos_d;
      play_bank_q  <= play_bank_d;
      write_bank_q <= write_bank_d;
      cap_idx_q    <= cap_idx_d;
      bank_full_q  <= bank_full_d;
      btn_pos_q    <= btn_pos_d;
      lfsr_q       <= lfsr_d;
    end
  end

endmodule

FILE: hw/rtl/msf_out.sv
// Back stage: memory data select, byte split and output register.
module msf_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msf_pkg::issue_t               issue_i,
  input  logic [7:0]                    cap_rdata_i,
  input  logic [7:0]                    sto_rdata_i,
  output logic                          take_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [msf_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import msf_pkg::*;

  logic                 s1_valid_q;
  issue_t               s1_q;
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 adv;
  logic [7:0]           src;
  logic [7:0]           ret;

  assign adv    = !out_valid_q || m_axis_tready_i;
  assign take_o = !s1_valid_q || adv;

  always_comb begin
    case (s1_q.sel)
      SRC_CAPTURE: src = cap_rdata_i;
      SRC_STORE:   src = sto_rdata_i;
      default:     src = s1_q.src_byte;
    endcase
    ret = s1_q.phase ? {src[0], 7'b0} : {1'b0, src[7:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        s1_valid_q <= issue_i.valid;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      s1_q <= issue_i;
    end
    if (adv && s1_valid_q) begin
      out_data_q <= {src, ret};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
